FILE: rtl/plss_pkg.sv
// Shared types and constants of the priority load-shedding switch.
`default_nettype none
package plss_pkg;

  localparam int NUM_SLOTS_DEF = 64;

  localparam int SLOT_W   = 6;
  localparam int RATE_W   = 16;
  localparam int PRIO_W   = 4;
  localparam int CAP_W    = 22;
  localparam int STATUS_W = 3;
  localparam int SHED_W   = 7;
  localparam int PADDR_W  = 3;

  localparam logic [CAP_W-1:0]  CAP_MAX       = 22'h3FFFFF;
  localparam logic [CAP_W-1:0]  CAP_RESET     = 22'd5000;
  localparam logic [SHED_W-1:0] SHED_MAX      = 7'd127;
  localparam logic [PRIO_W-1:0] CRIT_PRIORITY = 4'd10;
  localparam logic [PRIO_W-1:0] PRIO_LAST     = 4'd15;

  localparam logic OP_REGISTER      = 1'b0;
  localparam logic REG_MAX_CAPACITY = 1'b0;

  localparam logic [STATUS_W-1:0] ST_REGISTERED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ON         = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OFF        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECTED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SHED_ON    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SHED_FAIL  = 3'd6;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [RATE_W-1:0] rate_watts;
    logic [PRIO_W-1:0] priority_req;
    logic              critical;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SHED_W-1:0]   shed_count;
    logic [CAP_W-1:0]    freed_watts;
    logic [CAP_W-1:0]    active_load;
  } result_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [PRIO_W-1:0] prio;
    logic              critical;
  } slot_entry_t;

endpackage
`default_nettype wire

FILE: rtl/priority_load_shedding_switch.sv
// Priority load-shedding switch: slot table, load scan and shedding sequencer.
// A command is taken when start is high and busy is low; busy stays high until the
// result strobe. The result is on res for the one cycle that done is high and cannot be
// held off. Every command ends with a scan of the slot table that sums the active load,
// one slot per cycle through the single read port of the slot memory, so a register,
// off or not-found command needs only that scan. Turning a slot on adds a second
// scan before it. When a critical slot has to shed, the table is then scanned once
// per priority level, 16 levels at most. max_capacity sits at byte address 0 of the
// APB port and resets to 5000 W.
`default_nettype none
module priority_load_shedding_switch #(
  parameter int NUM_SLOTS = plss_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire plss_pkg::cmd_t                 cmd,
  output logic                                done,
  output plss_pkg::result_t                   res,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [plss_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import plss_pkg::*;

  localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int LOAD_W = CNT_W + RATE_W;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CAPTURE = 5'b00010,
    S_SUM     = 5'b00100,
    S_SHED    = 5'b01000,
    S_FINAL   = 5'b10000
  } state_t;

  state_t               state;
  logic [CAP_W-1:0]     max_capacity;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [NUM_SLOTS-1:0] slot_on;
  slot_entry_t          slot_mem [NUM_SLOTS];
  slot_entry_t          mem_q;

  logic [IDX_W-1:0]     sidx;
  logic [RATE_W-1:0]    need;
  logic                 crit_s;
  logic [CNT_W-1:0]     idx;
  logic                 pend;
  logic [IDX_W-1:0]     pend_idx;
  logic [LOAD_W-1:0]    acc;
  logic [LOAD_W-1:0]    freed_hold;
  logic [CNT_W-1:0]     shed_cnt;
  logic [PRIO_W-1:0]    pass;
  logic [STATUS_W-1:0]  status;

  logic                 accept;
  logic                 in_range;
  logic [IDX_W-1:0]     cidx;
  logic [IDX_W-1:0]     rd_addr;
  logic                 issue;
  logic                 scan_last;
  logic                 hit;
  logic [LOAD_W-1:0]    acc_sum;
  logic                 fits;
  logic                 need_met;
  logic                 shed_hit;
  logic                 cfg_wr;
  slot_entry_t          wr_entry;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign in_range = (32'(cmd.slot) < NUM_SLOTS);
  assign cidx     = IDX_W'(cmd.slot);

  assign wr_entry.rate     = cmd.rate_watts;
  assign wr_entry.prio     = cmd.critical ? CRIT_PRIORITY : cmd.priority_req;
  assign wr_entry.critical = cmd.critical;

  // Idle: read the addressed slot so its rate is ready right after the transfer.
  assign rd_addr   = (state == S_IDLE) ? cidx : idx[IDX_W-1:0];
  assign issue     = (idx < CNT_W'(NUM_SLOTS));
  assign scan_last = !issue && !pend;
  assign hit       = pend && slot_valid[pend_idx] && slot_on[pend_idx];
  assign acc_sum   = acc + LOAD_W'(mem_q.rate);
  assign fits      = (32'(acc) + 32'(need)) <= 32'(max_capacity);
  assign need_met  = acc >= LOAD_W'(need);
  assign shed_hit  = hit && !mem_q.critical && (mem_q.prio == pass);

  always_ff @(posedge clk) begin
    if (accept && in_range && cmd.op == OP_REGISTER) begin
      slot_mem[cidx] <= wr_entry;
    end
    mem_q <= slot_mem[rd_addr];
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_CAPACITY) ? 32'(max_capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      max_capacity <= CAP_RESET;
      slot_valid   <= '0;
      slot_on      <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr && paddr[2] == REG_MAX_CAPACITY) begin
        max_capacity <= pwdata[CAP_W-1:0];
      end

      // Scan engine: issue one slot read a cycle, process it the cycle after.
      if (issue) begin
        pend     <= 1'b1;
        pend_idx <= idx[IDX_W-1:0];
        idx      <= idx + CNT_W'(1);
      end else begin
        pend <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            sidx       <= cidx;
            freed_hold <= '0;
            shed_cnt   <= '0;
            acc        <= '0;
            idx        <= '0;
            pend       <= 1'b0;
            state      <= S_FINAL;
            if (!in_range) begin
              status <= ST_NOT_FOUND;
            end else if (cmd.op == OP_REGISTER) begin
              slot_valid[cidx] <= 1'b1;
              slot_on[cidx]    <= 1'b0;
              status           <= ST_REGISTERED;
            end else if (!slot_valid[cidx]) begin
              status <= ST_NOT_FOUND;
            end else if (slot_on[cidx]) begin
              slot_on[cidx] <= 1'b0;
              status        <= ST_OFF;
            end else begin
              state <= S_CAPTURE;
            end
          end
        end

        S_CAPTURE: begin
          need   <= mem_q.rate;
          crit_s <= mem_q.critical;
          acc    <= '0;
          idx    <= '0;
          pend   <= 1'b0;
          state  <= S_SUM;
        end

        S_SUM: begin
          if (hit) begin
            acc <= acc_sum;
          end
          if (scan_last) begin
            acc  <= '0;
            idx  <= '0;
            pend <= 1'b0;
            if (fits) begin
              slot_on[sidx] <= 1'b1;
              status        <= ST_ON;
              state         <= S_FINAL;
            end else if (!crit_s) begin
              status <= ST_REJECTED;
              state  <= S_FINAL;
            end else begin
              pass  <= '0;
              state <= S_SHED;
            end
          end
        end

        S_SHED: begin
          if (need_met) begin
            slot_on[sidx] <= 1'b1;
            status        <= ST_SHED_ON;
            freed_hold    <= acc;
            acc           <= '0;
            idx           <= '0;
            pend          <= 1'b0;
            state         <= S_FINAL;
          end else if (shed_hit) begin
            slot_on[pend_idx] <= 1'b0;
            acc               <= acc_sum;
            shed_cnt          <= shed_cnt + CNT_W'(1);
          end else if (scan_last) begin
            idx  <= '0;
            pend <= 1'b0;
            if (pass == PRIO_LAST) begin
              status     <= ST_SHED_FAIL;
              freed_hold <= acc;
              acc        <= '0;
              state      <= S_FINAL;
            end else begin
              pass <= pass + PRIO_W'(1);
            end
          end
        end

        S_FINAL: begin
          if (hit) begin
            acc <= acc_sum;
          end
          if (scan_last) begin
            res.status      <= status;
            res.shed_count  <= (32'(shed_cnt) > 32'(SHED_MAX)) ? SHED_MAX : SHED_W'(shed_cnt);
            res.freed_watts <= (32'(freed_hold) > 32'(CAP_MAX)) ? CAP_MAX
                                                                 : CAP_W'(freed_hold);
            res.active_load <= (32'(acc) > 32'(CAP_MAX)) ? CAP_MAX : CAP_W'(acc);
            done            <= 1'b1;
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
